[sv/kdlp_pkg.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// kdlp_pkg
// Shared types and constants for the key debouncer with long-press detection.
// ---------------------------------------------------------------------------
package kdlp_pkg;

    localparam int NUM_KEYS_DEF  = 4;
    localparam int TIME_W        = 32;
    localparam int MS_CFG_W      = 16;
    localparam int KEY_LEVEL_W   = 4;
    localparam int KEY_INDEX_W   = 2;
    localparam int EVENT_W       = 2;
    localparam int MAX_EVENTS    = 4;
    localparam int EV_CNT_W      = $clog2(MAX_EVENTS);
    localparam int CFG_INDEX_W   = 1;
    localparam int CFG_DATA_W    = 16;

    // register indexes of the configuration port
    localparam logic [CFG_INDEX_W-1:0] REG_DEBOUNCE   = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_LONG_PRESS = 1'b1;

    localparam logic [MS_CFG_W-1:0] DEBOUNCE_RST   = 16'd50;
    localparam logic [MS_CFG_W-1:0] LONG_PRESS_RST = 16'd1000;

    typedef enum logic [2:0] {
        PH_UP       = 3'd0,
        PH_DEB_DOWN = 3'd1,
        PH_DOWN     = 3'd2,
        PH_LONG     = 3'd3,
        PH_DEB_UP   = 3'd4
    } t_phase;

    typedef enum logic [EVENT_W-1:0] {
        EV_PRESS   = 2'd0,
        EV_LONG    = 2'd1,
        EV_RELEASE = 2'd2
    } t_event;

    typedef struct packed {
        logic   valid;
        t_event kind;
    } t_key_event;

endpackage : kdlp_pkg
`default_nettype wire

[sv/kdlp_key.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// kdlp_key
// Per-key phase machine and press timestamp; reports the event a poll causes.
// ---------------------------------------------------------------------------
module kdlp_key
    import kdlp_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_load,
    input  wire logic                i_pressed,
    input  wire logic [TIME_W-1:0]   i_now_ms,
    input  wire logic [MS_CFG_W-1:0] i_debounce_ms,
    input  wire logic [MS_CFG_W-1:0] i_long_press_ms,
    output t_key_event               o_event
);

    t_phase            r_phase, n_phase;
    logic [TIME_W-1:0] r_stamp, n_stamp;
    logic [TIME_W-1:0] w_elapsed;
    logic              w_deb_over;
    logic              w_long_over;

    // modular difference handles wrap of the millisecond clock
    assign w_elapsed   = i_now_ms - r_stamp;
    assign w_deb_over  = w_elapsed > TIME_W'(i_debounce_ms);
    assign w_long_over = w_elapsed > TIME_W'(i_long_press_ms);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_UP;
            r_stamp <= '0;
        end else if (i_load) begin
            r_phase <= n_phase;
            r_stamp <= n_stamp;
        end
    end

    always_comb begin
        n_phase       = r_phase;
        n_stamp       = r_stamp;
        o_event.valid = 1'b0;
        o_event.kind  = EV_PRESS;
        unique case (r_phase)
            PH_DEB_DOWN: begin
                if (!i_pressed) begin
                    n_phase = PH_UP;
                end else if (w_deb_over) begin
                    n_phase       = PH_DOWN;
                    o_event.valid = 1'b1;
                    o_event.kind  = EV_PRESS;
                end
            end
            PH_DOWN: begin
                if (!i_pressed) begin
                    n_phase = PH_DEB_UP;
                    n_stamp = i_now_ms;
                end else if (w_long_over) begin
                    n_phase       = PH_LONG;
                    o_event.valid = 1'b1;
                    o_event.kind  = EV_LONG;
                end
            end
            PH_LONG: begin
                if (!i_pressed) begin
                    n_phase = PH_DEB_UP;
                    n_stamp = i_now_ms;
                end
            end
            PH_DEB_UP: begin
                // bounce restarts the release timer
                if (i_pressed) begin
                    n_stamp = i_now_ms;
                end else if (w_deb_over) begin
                    n_phase       = PH_UP;
                    o_event.valid = 1'b1;
                    o_event.kind  = EV_RELEASE;
                end
            end
            default: begin
                n_phase = PH_UP;
                if (i_pressed) begin
                    n_phase = PH_DEB_DOWN;
                    n_stamp = i_now_ms;
                end
            end
        endcase
    end

endmodule : kdlp_key
`default_nettype wire

[sv/key_debounce_long_press_top.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// key_debounce_long_press_top
// Debounces NUM_KEYS active-low keys and reports press, long-press and
// release events, one event item per key in ascending key order.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one poll item: the current
//   millisecond time and one raw level bit per key. All key machines update in
//   the cycle the poll is accepted; their events are captured in an event
//   buffer and leave on the output channel (o_out_valid / i_out_ready), one
//   event item per cycle while i_out_ready is high, the last one of a poll
//   flagged by o_last_event. At most four events are sent per poll; further
//   ones are dropped. The first event is valid the cycle after the poll is
//   accepted. A poll that causes events holds the event buffer until its
//   last event is taken; a poll that causes no event does not use it, so
//   polls can follow every cycle. The next poll is taken in the same cycle
//   the last event of the previous poll is taken.
//   If the receiver stalls, the buffer holds and o_in_ready stays low.
//   Reset puts every key in the up phase, clears timestamps and the buffer,
//   and loads debounce 50 ms and long press 1000 ms. Configuration writes
//   are taken at any edge with i_cfg_we high.
// ---------------------------------------------------------------------------
module key_debounce_long_press_top
    import kdlp_pkg::*;
#(
    parameter int NUM_KEYS = NUM_KEYS_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  i_cfg_data,
    input  wire logic                   i_in_valid,
    output logic                        o_in_ready,
    input  wire logic [TIME_W-1:0]      i_now_ms,
    input  wire logic [KEY_LEVEL_W-1:0] i_key_levels,
    output logic                        o_out_valid,
    input  wire logic                   i_out_ready,
    output logic [KEY_INDEX_W-1:0]      o_key_index,
    output logic [EVENT_W-1:0]          o_event_kind,
    output logic                        o_last_event
);

    logic [MS_CFG_W-1:0] r_debounce_ms;
    logic [MS_CFG_W-1:0] r_long_press_ms;

    logic                      w_in_acc;
    logic                      w_out_acc;
    logic [NUM_KEYS-1:0]       w_pressed;
    t_key_event                w_key_ev [NUM_KEYS];

    logic [NUM_KEYS-1:0]       r_ev_pend, n_ev_pend;
    logic [EVENT_W-1:0]        r_ev_kind [NUM_KEYS];
    logic [EV_CNT_W-1:0]       r_ev_cnt, n_ev_cnt;
    logic [NUM_KEYS-1:0]       w_pend_low;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce_ms   <= DEBOUNCE_RST;
            r_long_press_ms <= LONG_PRESS_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_DEBOUNCE:   r_debounce_ms   <= i_cfg_data[MS_CFG_W-1:0];
                REG_LONG_PRESS: r_long_press_ms <= i_cfg_data[MS_CFG_W-1:0];
                default:        ;
            endcase
        end
    end

    assign w_in_acc  = i_in_valid && o_in_ready;
    assign w_out_acc = o_out_valid && i_out_ready;

    genvar k;
    generate
        for (k = 0; k < NUM_KEYS; k++) begin : g_key
            // keys without a level bit read as released
            if (k < KEY_LEVEL_W) begin : g_pin
                assign w_pressed[k] = ~i_key_levels[k];
            end else begin : g_nopin
                assign w_pressed[k] = 1'b0;
            end

            kdlp_key u_key (
                .i_clk           (i_clk),
                .i_rst_n         (i_rst_n),
                .i_load          (w_in_acc),
                .i_pressed       (w_pressed[k]),
                .i_now_ms        (i_now_ms),
                .i_debounce_ms   (r_debounce_ms),
                .i_long_press_ms (r_long_press_ms),
                .o_event         (w_key_ev[k])
            );

            always_ff @(posedge i_clk) begin
                if (w_in_acc) begin
                    r_ev_kind[k] <= w_key_ev[k].kind;
                end
            end
        end
    endgenerate

    // lowest pending key goes out first
    assign w_pend_low = r_ev_pend & ((~r_ev_pend) + NUM_KEYS'(1));

    always_comb begin
        o_key_index  = '0;
        o_event_kind = '0;
        for (int j = 0; j < NUM_KEYS; j++) begin
            if (w_pend_low[j]) begin
                o_key_index  = o_key_index | KEY_INDEX_W'(j);
                o_event_kind = o_event_kind | r_ev_kind[j];
            end
        end
    end

    assign o_out_valid  = |r_ev_pend;
    assign o_last_event = ((r_ev_pend & ~w_pend_low) == '0) ||
                          (r_ev_cnt == EV_CNT_W'(MAX_EVENTS - 1));
    assign o_in_ready   = !o_out_valid || (i_out_ready && o_last_event);

    always_comb begin
        n_ev_pend = r_ev_pend;
        n_ev_cnt  = r_ev_cnt;
        priority if (w_in_acc) begin
            for (int j = 0; j < NUM_KEYS; j++) begin
                n_ev_pend[j] = w_key_ev[j].valid;
            end
            n_ev_cnt = '0;
        end else if (w_out_acc) begin
            // the event limit drops whatever is left after the last item
            n_ev_pend = o_last_event ? '0 : (r_ev_pend & ~w_pend_low);
            n_ev_cnt  = r_ev_cnt + EV_CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ev_pend <= '0;
            r_ev_cnt  <= '0;
        end else begin
            r_ev_pend <= n_ev_pend;
            r_ev_cnt  <= n_ev_cnt;
        end
    end

endmodule : key_debounce_long_press_top
`default_nettype wire

[bench/tb_top.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// tb_top
// Checks the key debouncer with long-press detection. Polls carry a time and
// four raw key levels; a software copy of the four key machines predicts
// the press, long-press and release events of each accepted poll. Every
// event leaving the block is compared field by field in arrival order.
// ---------------------------------------------------------------------------
module tb_top;
    import kdlp_pkg::*;

    typedef struct {
        logic [KEY_INDEX_W-1:0] key;
        t_event                 kind;
        logic                   last;
    } key_event_s;

    logic                   i_clk        = 1'b0;
    logic                   i_rst_n      = 1'b0;
    logic                   i_cfg_we     = 1'b0;
    logic [CFG_INDEX_W-1:0] i_cfg_index  = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data   = '0;
    logic                   i_in_valid   = 1'b0;
    logic [TIME_W-1:0]      i_now_ms     = '0;
    logic [KEY_LEVEL_W-1:0] i_key_levels = '1;
    logic                   i_out_ready  = 1'b0;
    logic                   o_in_ready;
    logic                   o_out_valid;
    logic [KEY_INDEX_W-1:0] o_key_index;
    logic [EVENT_W-1:0]     o_event_kind;
    logic                   o_last_event;

    key_debounce_long_press_top DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_now_ms     (i_now_ms),
        .i_key_levels (i_key_levels),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_key_index  (o_key_index),
        .o_event_kind (o_event_kind),
        .o_last_event (o_last_event)
    );

    always #2 i_clk = ~i_clk;

    // predicted key machines
    t_phase                key_state [NUM_KEYS_DEF];
    logic [TIME_W-1:0]     key_since [NUM_KEYS_DEF];
    logic [MS_CFG_W-1:0]   deb_ms;
    logic [MS_CFG_W-1:0]   long_ms;
    key_event_s            events_due [$];

    int                    errors        = 0;
    int                    send_idle_pct = 0;
    int                    stall_pct     = 0;
    logic [TIME_W-1:0]     cur_ms;
    logic [KEY_LEVEL_W-1:0] held = '0;

    function automatic void reset_keys();
        for (int k = 0; k < NUM_KEYS_DEF; k++) begin
            key_state[k] = PH_UP;
            key_since[k] = '0;
        end
        deb_ms  = DEBOUNCE_RST;
        long_ms = LONG_PRESS_RST;
    endfunction

    function automatic void advance_keys(input logic [TIME_W-1:0] now,
                                         input logic [KEY_LEVEL_W-1:0] levels);
        key_event_s        found [$];
        key_event_s        ev;
        logic              pressed;
        logic              fire;
        t_event            kind;
        logic [TIME_W-1:0] elapsed;
        for (int k = 0; k < NUM_KEYS_DEF; k++) begin
            pressed = !levels[k];
            elapsed = now - key_since[k];
            fire    = 1'b0;
            kind    = EV_PRESS;
            case (key_state[k])
                PH_DEB_DOWN: begin
                    if (!pressed) begin
                        key_state[k] = PH_UP;
                    end else if (elapsed > deb_ms) begin
                        key_state[k] = PH_DOWN;
                        fire = 1'b1;
                        kind = EV_PRESS;
                    end
                end
                PH_DOWN: begin
                    if (!pressed) begin
                        key_state[k] = PH_DEB_UP;
                        key_since[k] = now;
                    end else if (elapsed > long_ms) begin
                        key_state[k] = PH_LONG;
                        fire = 1'b1;
                        kind = EV_LONG;
                    end
                end
                PH_LONG: begin
                    if (!pressed) begin
                        key_state[k] = PH_DEB_UP;
                        key_since[k] = now;
                    end
                end
                PH_DEB_UP: begin
                    // a bounce restarts the release timer
                    if (pressed) begin
                        key_since[k] = now;
                    end else if (elapsed > deb_ms) begin
                        key_state[k] = PH_UP;
                        fire = 1'b1;
                        kind = EV_RELEASE;
                    end
                end
                default: begin
                    key_state[k] = PH_UP;
                    if (pressed) begin
                        key_since[k] = now;
                        key_state[k] = PH_DEB_DOWN;
                    end
                end
            endcase
            if (fire && found.size() < MAX_EVENTS) begin
                ev.key  = KEY_INDEX_W'(k);
                ev.kind = kind;
                ev.last = 1'b0;
                found.push_back(ev);
            end
        end
        if (found.size() > 0) begin
            found[found.size()-1].last = 1'b1;
        end
        foreach (found[n]) begin
            events_due.push_back(found[n]);
        end
    endfunction

    task automatic report_mismatch(input string msg);
        errors++;
        if (errors <= 100) begin
            $display("mismatch at %0t: %s", $realtime, msg);
        end
    endtask

    // receiver side
    always @(negedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge i_clk) begin
        key_event_s want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (events_due.size() == 0) begin
                report_mismatch($sformatf("event key %0d kind %0d with none due",
                                          o_key_index, o_event_kind));
            end else begin
                want = events_due.pop_front();
                if (o_key_index !== want.key)
                    report_mismatch($sformatf("key_index expected %0d got %0d",
                                              want.key, o_key_index));
                if (o_event_kind !== want.kind)
                    report_mismatch($sformatf("event_kind expected %0d got %0d",
                                              want.kind, o_event_kind));
                if (o_last_event !== want.last)
                    report_mismatch($sformatf("last_event expected %0d got %0d",
                                              want.last, o_last_event));
            end
        end
    end

    task automatic set_idling(input int phase);
        case (phase)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 79; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 79; end
            default: begin send_idle_pct = 26; stall_pct = 26; end
        endcase
    endtask

    task automatic send_poll(input logic [TIME_W-1:0] now,
                             input logic [KEY_LEVEL_W-1:0] levels);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_now_ms     <= now;
        i_key_levels <= levels;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
        advance_keys(now, levels);
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (events_due.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        if (idx == REG_DEBOUNCE) begin
            deb_ms = value;
        end else begin
            long_ms = value;
        end
    endtask

    // reset thresholds: exact boundaries, long press, release bounce, all keys
    task automatic test_default_timing();
        set_idling(0);
        send_poll(32'd0,    4'hF);
        send_poll(32'd100,  4'hE);
        send_poll(32'd150,  4'hE);
        send_poll(32'd151,  4'hE);
        send_poll(32'd1100, 4'hE);
        send_poll(32'd1101, 4'hE);
        send_poll(32'd1200, 4'hF);
        send_poll(32'd1220, 4'hE);
        send_poll(32'd1270, 4'hF);
        send_poll(32'd1271, 4'hF);
        // press that bounces back before confirmation
        send_poll(32'd1300, 4'hD);
        send_poll(32'd1310, 4'hF);
        // short press without long event
        send_poll(32'd1400, 4'hD);
        send_poll(32'd1500, 4'hD);
        send_poll(32'd1600, 4'hF);
        send_poll(32'd1700, 4'hF);
        // all keys together, four events per poll
        send_poll(32'd2000, 4'h0);
        send_poll(32'd2051, 4'h0);
        send_poll(32'd3001, 4'h0);
        send_poll(32'd3100, 4'hF);
        send_poll(32'd3151, 4'hF);
        // elapsed time across the wrap of the clock
        send_poll(32'hFFFF_FFF0, 4'h7);
        send_poll(32'hFFFF_FFFF, 4'h7);
        send_poll(32'h0000_0022, 4'h7);
        send_poll(32'h0000_0023, 4'h7);
        wait_drained();
    endtask

    // zero thresholds: one millisecond is already past both
    task automatic test_zero_thresholds();
        set_idling(3);
        write_reg(REG_DEBOUNCE, 16'd0);
        write_reg(REG_LONG_PRESS, 16'd0);
        send_poll(32'h100, 4'h6);
        send_poll(32'h100, 4'h6);
        send_poll(32'h101, 4'h6);
        send_poll(32'h101, 4'h6);
        send_poll(32'h102, 4'hF);
        send_poll(32'h102, 4'hF);
        send_poll(32'h103, 4'hF);
        wait_drained();
    endtask

    task automatic random_polls(input int count);
        logic [TIME_W-1:0]      step;
        logic [KEY_LEVEL_W-1:0] bounce;
        for (int n = 0; n < count; n++) begin
            case ($urandom_range(15))
                0:        step = '0;
                1:        step = 32'd1;
                2, 3:     step = deb_ms + $urandom_range(2) - 1;
                4, 5:     step = long_ms + $urandom_range(2) - 1;
                6, 7, 8, 9, 10: step = $urandom_range(deb_ms + 1);
                11, 12, 13:     step = $urandom_range(long_ms / 4 + 1);
                14:       step = $urandom_range(deb_ms * 2 + 2);
                default:  step = $urandom;
            endcase
            cur_ms = cur_ms + step;
            for (int k = 0; k < KEY_LEVEL_W; k++) begin
                if ($urandom_range(99) < 15) held[k] = ~held[k];
            end
            bounce = ($urandom_range(9) == 0) ? (4'b1 << $urandom_range(3)) : 4'b0;
            send_poll(cur_ms, ~held ^ bounce);
        end
    endtask

    task automatic test_random_settings();
        logic [MS_CFG_W-1:0] deb_set  [6];
        logic [MS_CFG_W-1:0] long_set [6];
        deb_set  = '{16'd50,   16'd0, 16'hFFFF, 16'd0,    16'hFFFF, 16'd0};
        long_set = '{16'd1000, 16'd0, 16'hFFFF, 16'hFFFF, 16'd0,    16'd0};
        deb_set[5]  = $urandom_range(200);
        long_set[5] = $urandom_range(3000);
        for (int s = 0; s < 6; s++) begin
            wait_drained();
            write_reg(REG_DEBOUNCE, deb_set[s]);
            write_reg(REG_LONG_PRESS, long_set[s]);
            cur_ms = (s == 3) ? 32'hFFFF_FF00 : $urandom;
            set_idling(s % 4);
            random_polls(50);
        end
        wait_drained();
    endtask

    initial begin
        reset_keys();
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_default_timing();
        test_zero_thresholds();
        test_random_settings();
        repeat (8) @(posedge i_clk);
        if (errors == 0 && events_due.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule : tb_top
`default_nettype wire

[filelist.f]
sv/kdlp_pkg.sv
sv/kdlp_key.sv
sv/key_debounce_long_press_top.sv
bench/tb_top.sv
